### hw/rtl/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// Types and constants shared by the homogeneous point transform files.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int NumRegs   = 8;
  localparam int RegIdxW   = 3;
  localparam int RegW      = 64;
  localparam int NumW      = 66;   // row sum width

  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_DIR   = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic               overflow_flag;
    logic               zero_w_flag;
  } out_item_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic                   dir;
    logic                   w_one;
    logic                   w_zero;
    logic signed [NumW-1:0] num0;
    logic signed [NumW-1:0] num1;
    logic signed [NumW-1:0] num2;
    logic signed [NumW-1:0] w;
  } work_t;

  function automatic logic signed [31:0] sat32(input logic signed [NumW-1:0] v,
                                               output logic ovf);
    logic signed [NumW-1:0] hi;
    logic signed [NumW-1:0] lo;
    begin
      hi = NumW'(64'sh7FFF_FFFF);
      lo = -NumW'(64'sh8000_0000);
      ovf = 1'b0;
      sat32 = v[31:0];
      if (v > hi) begin
        ovf = 1'b1;
        sat32 = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
        ovf = 1'b1;
        sat32 = 32'sh8000_0000;
      end
    end
  endfunction

endpackage

### hw/rtl/hpt_front.sv
// ----------------------------------------------------------------------------
// hpt_front
// Matrix registers and pipelined multiply-accumulate for all four rows.
// ----------------------------------------------------------------------------
module hpt_front import hpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [RegIdxW-1:0]    cfg_idx,
  input  logic [RegW-1:0]       cfg_data,
  input  logic                  in_valid,
  input  in_item_t              in_item,
  input  logic                  advance,
  output logic                  out_valid,
  output work_t                 out_work
);

  localparam logic [31:0] One = 32'(64'd1 << FRAC_BITS);

  logic [RegW-1:0] mat [NumRegs];

  always_ff @(posedge clk) begin
    if (rst) begin
      mat[0] <= {32'd0, One};
      mat[1] <= '0;
      mat[2] <= {One, 32'd0};
      mat[3] <= '0;
      mat[4] <= '0;
      mat[5] <= {32'd0, One};
      mat[6] <= '0;
      mat[7] <= {One, 32'd0};
    end else if (cfg_we) begin
      mat[cfg_idx] <= cfg_data;
    end
  end

  // Stage 1: twelve products.
  logic              s1_valid, s2_valid;
  logic              s1_dir, s2_dir;
  logic signed [63:0] prod [4][3];
  logic signed [31:0] trans [4];
  logic signed [NumW-1:0] sum [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_dir <= in_item.cmd;
      for (int r = 0; r < 4; r++) begin
        prod[r][0] <= $signed(mat[2*r][31:0])    * in_item.x_in;
        prod[r][1] <= $signed(mat[2*r][63:32])   * in_item.y_in;
        prod[r][2] <= $signed(mat[2*r+1][31:0])  * in_item.z_in;
        trans[r]   <= $signed(mat[2*r+1][63:32]);
      end
      // Stage 2: floor-shifted terms summed, plus translation for points only.
      s2_dir <= s1_dir;
      for (int r = 0; r < 4; r++) begin
        sum[r] <= NumW'(prod[r][0] >>> FRAC_BITS) + NumW'(prod[r][1] >>> FRAC_BITS)
                + NumW'(prod[r][2] >>> FRAC_BITS)
                + ((s1_dir == CMD_DIR) ? NumW'(0) : NumW'(trans[r]));
      end
    end
  end

  assign out_valid       = s2_valid;
  assign out_work.dir    = s2_dir;
  assign out_work.num0   = sum[0];
  assign out_work.num1   = sum[1];
  assign out_work.num2   = sum[2];
  assign out_work.w      = sum[3];
  assign out_work.w_one  = (sum[3] == NumW'(One));
  assign out_work.w_zero = (sum[3] == '0);

endmodule

### hw/rtl/hpt_queue.sv
// ----------------------------------------------------------------------------
// hpt_queue
// Small FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module hpt_queue import hpt_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  work_t wdata,
  input  logic  rd,
  output work_t rdata,
  output logic  empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  work_t            mem [DEPTH];
  logic [AW-1:0]    wptr, rptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      if (rd) rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      count <= count + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wdata;
  end

  assign rdata = mem[rptr];
  assign empty = (count == '0);

endmodule

### hw/rtl/hpt_back.sv
// ----------------------------------------------------------------------------
// hpt_back
// Pipelined restoring divider for the three coordinates plus saturation.
// ----------------------------------------------------------------------------
module hpt_back import hpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  work_t     in_work,
  input  logic      advance,
  output logic      out_valid,
  output out_item_t out_item
);

  // Dividend is |num| << FRAC_BITS; quotient bits above bit 31 only flag
  // saturation, so the divider runs over the full dividend width.
  localparam int DW = NumW + FRAC_BITS;
  localparam int NS = DW;

  typedef struct packed {
    logic            dir;
    logic            w_one;
    logic            w_zero;
    logic [2:0]      neg;
    logic [2:0]      nz;
    logic signed [NumW-1:0] n0, n1, n2;
    logic [NumW-1:0] den;
  } ctl_t;

  logic          vld  [NS+1];
  ctl_t          ctl  [NS+1];
  logic [DW-1:0] rem  [NS+1][3];
  logic [DW-1:0] quo  [NS+1][3];
  logic [DW-1:0] dvd  [NS+1][3];

  logic [NumW-1:0] an [3];
  logic signed [NumW-1:0] nums [3];
  logic [NumW-1:0] aw;

  always_comb begin
    nums[0] = in_work.num0;
    nums[1] = in_work.num1;
    nums[2] = in_work.num2;
    for (int k = 0; k < 3; k++) begin
      an[k] = nums[k][NumW-1] ? NumW'(-nums[k]) : NumW'(nums[k]);
    end
    aw = in_work.w[NumW-1] ? NumW'(-in_work.w) : NumW'(in_work.w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= NS; s++) vld[s] <= 1'b0;
    end else if (advance) begin
      vld[0] <= in_valid;
      for (int s = 1; s <= NS; s++) vld[s] <= vld[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctl[0].dir    <= in_work.dir;
      ctl[0].w_one  <= in_work.w_one;
      ctl[0].w_zero <= in_work.w_zero;
      ctl[0].n0     <= in_work.num0;
      ctl[0].n1     <= in_work.num1;
      ctl[0].n2     <= in_work.num2;
      ctl[0].den    <= aw;
      for (int k = 0; k < 3; k++) begin
        ctl[0].neg[k] <= nums[k][NumW-1] ^ in_work.w[NumW-1];
        ctl[0].nz[k]  <= (nums[k] != '0);
        rem[0][k] <= '0;
        quo[0][k] <= '0;
        dvd[0][k] <= {an[k], FRAC_BITS'(0)};
      end
      // One quotient bit per stage.
      for (int s = 1; s <= NS; s++) begin
        ctl[s] <= ctl[s-1];
        for (int k = 0; k < 3; k++) begin
          logic [DW:0] tr;
          tr = {rem[s-1][k], dvd[s-1][k][DW-1]};
          if (tr >= {{(DW+1-NumW){1'b0}}, ctl[s-1].den}) begin
            rem[s][k] <= DW'(tr - {{(DW+1-NumW){1'b0}}, ctl[s-1].den});
            quo[s][k] <= {quo[s-1][k][DW-2:0], 1'b1};
          end else begin
            rem[s][k] <= DW'(tr);
            quo[s][k] <= {quo[s-1][k][DW-2:0], 1'b0};
          end
          dvd[s][k] <= {dvd[s-1][k][DW-2:0], 1'b0};
        end
      end
    end
  end

  // Final selection and saturation.
  ctl_t c;
  logic signed [NumW-1:0] fn [3];
  logic signed [31:0] res [3];
  logic o [3];
  logic signed [NumW-1:0] qv;
  always_comb begin
    c = ctl[NS];
    fn[0] = c.n0;
    fn[1] = c.n1;
    fn[2] = c.n2;
    qv = '0;
    for (int k = 0; k < 3; k++) begin
      if (c.dir == CMD_DIR || c.w_one) begin
        res[k] = sat32(fn[k], o[k]);
      end else if (c.w_zero) begin
        o[k] = c.nz[k];
        res[k] = !c.nz[k] ? 32'sd0 : (fn[k][NumW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
      end else if (quo[NS][k][DW-1:32] != '0) begin
        o[k] = 1'b1;
        res[k] = c.neg[k] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        qv = NumW'(quo[NS][k][31:0]);
        res[k] = sat32(c.neg[k] ? -qv : qv, o[k]);
      end
    end
  end

  assign out_valid              = vld[NS];
  assign out_item.x_out         = res[0];
  assign out_item.y_out         = res[1];
  assign out_item.z_out         = res[2];
  assign out_item.overflow_flag = o[0] | o[1] | o[2];
  assign out_item.zero_w_flag   = (c.dir == CMD_POINT) && c.w_zero;

endmodule

### hw/rtl/homogeneous_point_transform_top.sv
// ----------------------------------------------------------------------------
// homogeneous_point_transform_top
// 4x4 fixed-point matrix transform of a 3-vector with perspective divide.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_item and raise push; a transfer happens when full
//   is low. Output queue: while empty is low, out_item holds the oldest
//   result; raise pop to transfer it. The user must write the matrix registers
//   through cfg_we/cfg_idx/cfg_data only while the block is idle, which it
//   does not enforce; reset loads the identity matrix and empties the pipeline.
// Timing:
//   One item per cycle sustained while results are popped. The front end
//   (two stages: products, row sums) feeds a small queue; the back end is a
//   restoring divider with an input stage and one quotient bit per stage,
//   82 stages at FRAC_BITS = 16 (NumW + FRAC_BITS). After its input
//   transfer a result passes through the two front stages, the queue, the
//   divider input stage and the divider stages to the output ports. The
//   divider stages are paid by every item.
//   When the receiver stalls, the back pipe holds its last result on the
//   outputs and stops, the middle queue takes items until its count exceeds
//   QD - 3 and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_top import hpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  in_item_t           in_item,
  input  logic               pop,
  output logic               empty,
  output out_item_t          out_item,
  input  logic               cfg_we,
  input  logic [RegIdxW-1:0] cfg_idx,
  input  logic [RegW-1:0]    cfg_data
);

  localparam int QD = 4;
  localparam int CW = $clog2(QD+1);

  logic  f_valid, f_adv;
  work_t f_work;
  logic  q_empty;
  logic [CW-1:0] q_count;
  work_t q_work;
  logic  b_valid, b_adv, q_rd;
  out_item_t b_item;

  // Front end advances while the middle queue has room for what is in flight
  // (two stages plus the one leaving).
  assign f_adv = (q_count <= CW'(QD - 3));
  assign full  = !f_adv;

  hpt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data,
    .in_valid(push && f_adv), .in_item, .advance(f_adv),
    .out_valid(f_valid), .out_work(f_work)
  );

  hpt_queue #(.DEPTH(QD)) u_queue (
    .clk, .rst, .wr(f_valid && f_adv), .wdata(f_work),
    .rd(q_rd), .rdata(q_work), .empty(q_empty), .count(q_count)
  );

  // Advance the back pipe when its last stage is empty or being popped.
  assign b_adv = pop || !b_valid;
  assign q_rd  = b_adv && !q_empty;

  hpt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .in_valid(q_rd), .in_work(q_work), .advance(b_adv),
    .out_valid(b_valid), .out_item(b_item)
  );

  // The last stage's result is the output; the back pipe stalls on it.
  assign empty    = !b_valid;
  assign out_item = b_item;

endmodule
